@@ sv/bb3_pkg.sv @@
package bb3_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int CHANNEL_BITS  = 8;
    localparam int PIX_BITS      = 3 * CHANNEL_BITS;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = 12;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_COUNT_MAX = 4095;
    localparam int SUM_BITS      = 12;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH      = 8;
    localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);

    localparam int ADDR_BITS    = 3;
    localparam int REG_IDX_BITS = 1;
    localparam int DATA_BITS    = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic                    req_type;
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } pix_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic                    row_end;
        logic                    frame_end;
    } blur_item_t;

    // one classified pixel or drain slot, handed from front to back
    typedef struct packed {
        logic [PIX_BITS-1:0] cur;
        logic [COL_BITS-1:0] col;
        logic                up_en;
        logic                mid_en;
        logic                wr_en;
        logic                due;
        logic                lm;
        logic                rm;
        logic                tm;
        logic                bm;
    } cmd_t;

endpackage

@@ sv/bb3_front.sv @@
module bb3_front
    import bb3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [WIDTH_BITS-1:0]  eff_width,
    input  logic [HEIGHT_BITS-1:0] eff_height,
    input  logic                   take,
    input  pix_item_t              pix,
    output logic                   push,
    output cmd_t                   cmd
);

    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_col_reg, out_col_next;
    logic [ROW_BITS-1:0] out_row_reg, out_row_next;
    logic                draining_reg, draining_next;

    logic                   ignore;
    logic [HEIGHT_BITS-1:0] row_eff;
    logic [WIDTH_BITS-1:0]  col_inc;
    logic [HEIGHT_BITS-1:0] in_row_inc;
    logic [WIDTH_BITS-1:0]  out_col_inc;
    logic [HEIGHT_BITS-1:0] out_row_inc;
    logic                   due, lm, rm, tm, bm;

    always_comb
    begin
        // drain beats before the frame is complete are dropped
        ignore      = pix.req_type && !draining_reg;
        row_eff     = draining_reg ? eff_height + HEIGHT_BITS'(in_row_reg)
                                   : HEIGHT_BITS'(in_row_reg);
        col_inc     = WIDTH_BITS'(in_col_reg) + 1'b1;
        in_row_inc  = HEIGHT_BITS'(in_row_reg) + 1'b1;
        out_col_inc = WIDTH_BITS'(out_col_reg) + 1'b1;
        out_row_inc = HEIGHT_BITS'(out_row_reg) + 1'b1;

        due = (row_eff >= HEIGHT_BITS'(2))
            || (row_eff == HEIGHT_BITS'(1) && in_col_reg != '0);
        lm  = out_col_reg == '0;
        rm  = out_col_inc >= eff_width;
        tm  = out_row_reg == '0;
        bm  = out_row_inc >= eff_height;

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;

        if (take && !ignore)
        begin
            if (col_inc >= eff_width)
            begin
                in_col_next = '0;
                if (draining_reg)
                begin
                    if (in_row_reg != ROW_BITS'(ROW_COUNT_MAX))
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else if (in_row_inc >= eff_height)
                begin
                    draining_next = 1'b1;
                    in_row_next   = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end

            if (due)
            begin
                if (rm && bm)
                begin
                    // last pixel of the frame goes out: start over
                    in_col_next   = '0;
                    in_row_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    draining_next = 1'b0;
                end
                else if (rm)
                begin
                    out_col_next = '0;
                    if (out_row_reg != ROW_BITS'(ROW_COUNT_MAX))
                    begin
                        out_row_next = out_row_reg + 1'b1;
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end

        push       = take && !ignore;
        cmd.cur    = draining_reg ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
        cmd.col    = in_col_reg;
        cmd.up_en  = row_eff >= HEIGHT_BITS'(2);
        cmd.mid_en = row_eff != '0;
        cmd.wr_en  = !draining_reg;
        cmd.due    = due;
        cmd.lm     = lm;
        cmd.rm     = rm;
        cmd.tm     = tm;
        cmd.bm     = bm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
        end
    end

endmodule

@@ sv/bb3_queue.sv @@
module bb3_queue
    import bb3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output logic valid,
    output cmd_t head,
    output logic full
);

    cmd_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    always_comb
    begin
        valid      = count_reg != '0;
        full       = count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
        head       = entry_reg[rd_ptr_reg];
        count_next = count_reg + (QUEUE_PTR_BITS + 1)'(push)
                   - (QUEUE_PTR_BITS + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/bb3_back.sv @@
module bb3_back
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       head,
    output logic       pop,
    output logic       blur_valid,
    output blur_item_t blur,
    input  logic       blur_stall
);

    localparam int RECIP3       = 2731;
    localparam int RECIP3_SHIFT = 13;
    localparam int RECIP9       = 7282;
    localparam int RECIP9_SHIFT = 16;
    localparam int PROD_BITS    = 26;

    function automatic logic [CHANNEL_BITS-1:0] div_round(
        input logic [SUM_BITS-1:0] s,
        input logic [3:0]          cnt
    );
        logic [SUM_BITS:0]    x;
        logic [SUM_BITS:0]    m3;
        logic [PROD_BITS-1:0] p3;
        logic [PROD_BITS-1:0] p9;
        logic [CHANNEL_BITS-1:0] q;
        x  = (SUM_BITS + 1)'(s) + (SUM_BITS + 1)'(cnt >> 1);
        // divide by six as halve then divide by three
        m3 = (cnt == 4'd6) ? (x >> 1) : x;
        p3 = PROD_BITS'(m3) * PROD_BITS'(RECIP3);
        p9 = PROD_BITS'(x) * PROD_BITS'(RECIP9);
        unique case (cnt)
            4'd1:       q = x[CHANNEL_BITS-1:0];
            4'd2:       q = x[CHANNEL_BITS:1];
            4'd4:       q = x[CHANNEL_BITS+1:2];
            4'd3, 4'd6: q = p3[RECIP3_SHIFT +: CHANNEL_BITS];
            4'd9:       q = p9[RECIP9_SHIFT +: CHANNEL_BITS];
            default:    q = '0;
        endcase
        return q;
    endfunction

    // line stores: {upper, middle} share one address
    logic [2*PIX_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_BITS-1:0] mem_rd_reg;
    logic [2*PIX_BITS-1:0] fwd_data_reg;
    logic                  fwd_reg;

    logic a_valid_reg;
    cmd_t a_cmd_reg;
    logic [PIX_BITS-1:0] a_up, a_mid;
    logic [2*PIX_BITS-1:0] a_rd;
    logic fwd;

    logic [PIX_BITS-1:0] win_reg [3][3];

    logic b_valid_reg;
    logic b_lm_reg, b_rm_reg, b_tm_reg, b_bm_reg;

    logic [SUM_BITS-1:0] sum_r, sum_g, sum_b;
    logic [1:0]          ncol, nrow;
    logic                c_valid_reg;
    logic [SUM_BITS-1:0] c_sum_r_reg, c_sum_g_reg, c_sum_b_reg;
    logic [3:0]          c_cnt_reg;
    logic                c_row_end_reg, c_frame_end_reg;

    blur_item_t              ofifo_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] owr_ptr_reg, ord_ptr_reg;
    logic [OUT_PTR_BITS:0]   ocount_reg;
    logic                    opop;
    logic [OUT_PTR_BITS+1:0] in_flight;
    blur_item_t              result;

    always_comb
    begin
        // results that may still land in the output queue
        in_flight = (OUT_PTR_BITS + 2)'(ocount_reg)
                  + (OUT_PTR_BITS + 2)'(a_valid_reg && a_cmd_reg.due)
                  + (OUT_PTR_BITS + 2)'(b_valid_reg)
                  + (OUT_PTR_BITS + 2)'(c_valid_reg);
        pop  = q_valid && (in_flight < (OUT_PTR_BITS + 2)'(OUT_DEPTH));

        a_rd  = fwd_reg ? fwd_data_reg : mem_rd_reg;
        a_up  = a_cmd_reg.up_en  ? a_rd[2*PIX_BITS-1:PIX_BITS] : '0;
        a_mid = a_cmd_reg.mid_en ? a_rd[PIX_BITS-1:0] : '0;
        // the entry being written this cycle is not yet visible to the read
        fwd   = a_valid_reg && a_cmd_reg.wr_en && (a_cmd_reg.col == head.col);
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && a_cmd_reg.wr_en)
        begin
            line_mem[a_cmd_reg.col] <= {a_mid, a_cmd_reg.cur};
        end
        if (pop)
        begin
            mem_rd_reg   <= line_mem[head.col];
            fwd_reg      <= fwd;
            fwd_data_reg <= {a_mid, a_cmd_reg.cur};
            a_cmd_reg    <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[c][r] <= '0;
                end
            end
        end
        else if (a_valid_reg)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= a_up;
            win_reg[2][1] <= a_mid;
            win_reg[2][2] <= a_cmd_reg.cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_lm_reg <= a_cmd_reg.lm;
            b_rm_reg <= a_cmd_reg.rm;
            b_tm_reg <= a_cmd_reg.tm;
            b_bm_reg <= a_cmd_reg.bm;
        end
    end

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (!((c == 0 && b_lm_reg) || (c == 2 && b_rm_reg)
                      || (r == 0 && b_tm_reg) || (r == 2 && b_bm_reg)))
                begin
                    sum_r = sum_r + SUM_BITS'(win_reg[c][r][3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
                    sum_g = sum_g + SUM_BITS'(win_reg[c][r][2*CHANNEL_BITS-1:CHANNEL_BITS]);
                    sum_b = sum_b + SUM_BITS'(win_reg[c][r][CHANNEL_BITS-1:0]);
                end
            end
        end
        ncol = 2'd3 - 2'(b_lm_reg) - 2'(b_rm_reg);
        nrow = 2'd3 - 2'(b_tm_reg) - 2'(b_bm_reg);
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            c_sum_r_reg     <= sum_r;
            c_sum_g_reg     <= sum_g;
            c_sum_b_reg     <= sum_b;
            c_cnt_reg       <= 4'(ncol) * 4'(nrow);
            c_row_end_reg   <= b_rm_reg;
            c_frame_end_reg <= b_rm_reg && b_bm_reg;
        end
    end

    always_comb
    begin
        result.red_out   = div_round(c_sum_r_reg, c_cnt_reg);
        result.green_out = div_round(c_sum_g_reg, c_cnt_reg);
        result.blue_out  = div_round(c_sum_b_reg, c_cnt_reg);
        result.row_end   = c_row_end_reg;
        result.frame_end = c_frame_end_reg;

        blur_valid = ocount_reg != '0;
        blur       = ofifo_reg[ord_ptr_reg];
        opop       = blur_valid && !blur_stall;
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg)
        begin
            ofifo_reg[owr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg && a_cmd_reg.due;
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (opop)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + (OUT_PTR_BITS + 1)'(c_valid_reg)
                        - (OUT_PTR_BITS + 1)'(opop);
        end
    end

endmodule

@@ sv/box_blur_3x3_edge_aware.sv @@
// 3x3 box blur on an RGB raster stream. One beat per clock is taken on the pix
// channel unless pix_stall is high, and one result per clock leaves on the blur
// channel unless blur_stall is high; the front stage tracks frame position and
// classifies each beat combinationally as it is taken, then hands it through a
// four-entry queue to the back end (line store read, window shift, channel sums,
// divide by the neighbor count), which has three register stages ahead of an
// eight-entry result queue, where blur_stall can hold results. A result's window
// is complete with the beat W+1 beats after the pixel itself, so after the last
// pixel of a frame the source sends W+1 drain beats (req_type high); drain beats
// sent before the frame is complete are dropped. The line stores are one 1024 x 48
// memory with at most one read and one write each cycle. frame_width (address 0)
// and frame_height (address 4) reset to 640 and 480; zero counts as 1 and larger
// values clamp to 1024 and 4096. Write them only between frames.
module box_blur_3x3_edge_aware
    import bb3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pix_item_t            pix,
    output logic                 blur_valid,
    input  logic                 blur_stall,
    output blur_item_t           blur,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic [WIDTH_BITS-1:0]   frame_width_reg;
    logic [HEIGHT_BITS-1:0]  frame_height_reg;
    logic [WIDTH_BITS-1:0]   eff_width;
    logic [HEIGHT_BITS-1:0]  eff_height;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    logic take;
    logic push;
    cmd_t cmd;
    logic q_valid;
    cmd_t q_head;
    logic q_full;
    logic q_pop;

    always_comb
    begin
        pready  = 1'b1;
        reg_idx = paddr[ADDR_BITS-1:2];
        wr_en   = psel && penable && pwrite && pready;

        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_BITS'(frame_height_reg);
            default:          prdata = '0;
        endcase

        if (frame_width_reg == '0)
            eff_width = WIDTH_BITS'(1);
        else if (frame_width_reg > WIDTH_BITS'(MAX_WIDTH))
            eff_width = WIDTH_BITS'(MAX_WIDTH);
        else
            eff_width = frame_width_reg;

        if (frame_height_reg == '0)
            eff_height = HEIGHT_BITS'(1);
        else if (frame_height_reg > HEIGHT_BITS'(HEIGHT_LIMIT))
            eff_height = HEIGHT_BITS'(HEIGHT_LIMIT);
        else
            eff_height = frame_height_reg;

        pix_stall = q_full;
        take      = pix_valid && !pix_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    bb3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .take       (take),
        .pix        (pix),
        .push       (push),
        .cmd        (cmd)
    );

    bb3_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (cmd),
        .pop    (q_pop),
        .valid  (q_valid),
        .head   (q_head),
        .full   (q_full)
    );

    bb3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .blur_valid (blur_valid),
        .blur       (blur),
        .blur_stall (blur_stall)
    );

`ifndef SYNTH
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (blur_valid && blur.frame_end) |-> blur.row_end)
        else $error("frame end without row end");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |-> !q_full)
        else $error("front pushed into a full queue");
`endif

endmodule
